@@ src/grid_diffusion_relaxation_core_assert.svh @@
// Assertion macros for the grid relaxation core.
`ifndef GRID_DIFFUSION_RELAXATION_CORE_ASSERT_SVH
`define GRID_DIFFUSION_RELAXATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define GDR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define GDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/gdr_pkg.sv @@
`default_nettype none

package gdr_pkg;

  localparam int CELL_W      = 16;
  localparam int FRAC_BITS   = 12;
  localparam int WEIGHT_W    = 13;
  localparam int INDEX_W     = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 32;

  localparam logic [WEIGHT_W-1:0] SELF_WEIGHT_RST      = 13'd3277;
  localparam logic [WEIGHT_W-1:0] NEIGHBOUR_WEIGHT_RST = 13'd205;
  localparam logic [CELL_W-1:0]   IMPULSE_AMOUNT_RST   = 16'd1638;

  localparam logic FUNC_STEP = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_SELF_WEIGHT      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOUR_WEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMPULSE_AMOUNT   = 2'd2;

  typedef enum logic [1:0] {
    WS_ZERO,
    WS_CELL,
    WS_IMPULSE
  } wsel_e;

  typedef struct packed {
    logic  mem_we;
    wsel_e wsel;
    logic  rd_en;
    logic  prep_en;
    logic  has_left;
    logic  has_right;
    logic  has_up;
    logic  has_down;
    logic  comp_en;
    logic  capture;
    logic  func_read;
    logic  cell_in_grid;
    logic  out_load;
  } cmd_t;

endpackage

`default_nettype wire

@@ src/gdr_if.sv @@
`default_nettype none

interface gdr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [gdr_pkg::INDEX_W-1:0]   cell_index;

  modport source (output valid, output func, output cell_index, input ready);
  modport sink   (input valid, input func, input cell_index, output ready);
endinterface

interface gdr_out_if;
  logic                          valid;
  logic                          ready;
  logic [gdr_pkg::CELL_W-1:0]    cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface gdr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gdr_pkg::CFG_INDEX_W-1:0]   reg_index;
  logic [gdr_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

@@ src/gdr_ctrl.sv @@
`default_nettype none

module gdr_ctrl #(
  parameter int GRID_WIDTH  = gdr_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gdr_pkg::GRID_HEIGHT_DEF,
  localparam int N   = GRID_WIDTH * GRID_HEIGHT,
  localparam int AW  = $clog2(N)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_func_i,
  input  wire logic [gdr_pkg::INDEX_W-1:0]   in_cell_index_i,
  output logic                               in_ready_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output gdr_pkg::cmd_t                      cmd_o,
  output logic [AW-1:0]                      waddr_o,
  output logic [AW-1:0]                      raddr_o
);

  localparam int KW  = $clog2(N + GRID_WIDTH + 2);
  localparam int CLW = $clog2(GRID_WIDTH);
  localparam int RWW = $clog2(GRID_HEIGHT);

  localparam logic [KW-1:0] K_CLR_LAST   = KW'(N - 1);
  localparam logic [KW-1:0] K_N          = KW'(N);
  localparam logic [KW-1:0] K_PREP_FIRST = KW'(GRID_WIDTH + 1);
  localparam logic [KW-1:0] K_PREP_LAST  = KW'(N + GRID_WIDTH);
  localparam logic [KW-1:0] K_OFF        = KW'(GRID_WIDTH + 2);
  localparam logic [KW-1:0] K_LAST       = KW'(N + GRID_WIDTH + 1);
  localparam logic [CLW-1:0] COL_LAST    = CLW'(GRID_WIDTH - 1);
  localparam logic [RWW-1:0] ROW_LAST    = RWW'(GRID_HEIGHT - 1);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_SWEEP   = 3'd2;
  localparam logic [2:0] ST_FETCH   = 3'd3;
  localparam logic [2:0] ST_CAPTURE = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [KW-1:0]                 k_q, k_d;
  logic [CLW-1:0]                pcol_q, pcol_d;
  logic [RWW-1:0]                prow_q, prow_d;
  logic                          out_valid_q, out_valid_d;
  logic                          func_q;
  logic [gdr_pkg::INDEX_W-1:0]   idx_q;
  logic                          in_grid;
  logic [AW-1:0]                 idx_addr;
  logic                          prep_en;
  logic                          comp_en;
  logic                          out_load;
  logic [KW-1:0]                 k_wr;

  assign in_grid  = 32'(idx_q) < 32'(N);
  assign idx_addr = in_grid ? AW'(idx_q) : '0;
  assign prep_en  = (state_q == ST_SWEEP) && (k_q >= K_PREP_FIRST) && (k_q <= K_PREP_LAST);
  assign comp_en  = (state_q == ST_SWEEP) && (k_q >= K_OFF);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign k_wr     = k_q - K_OFF;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    pcol_d      = pcol_q;
    prow_d      = prow_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
    case (state_q)
      ST_CLEAR: begin
        k_d = k_q + 1'b1;
        if (k_q == K_CLR_LAST) begin
          k_d     = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        k_d    = '0;
        pcol_d = '0;
        prow_d = '0;
        if (in_valid_i) begin
          state_d = (in_func_i == gdr_pkg::FUNC_STEP) ? ST_SWEEP : ST_FETCH;
        end
      end
      ST_SWEEP: begin
        k_d = k_q + 1'b1;
        if (prep_en) begin
          if (pcol_q == COL_LAST) begin
            pcol_d = '0;
            prow_d = prow_q + 1'b1;
          end else begin
            pcol_d = pcol_q + 1'b1;
          end
        end
        if (k_q == K_LAST) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= '0;
      pcol_q      <= '0;
      prow_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      pcol_q      <= pcol_d;
      prow_q      <= prow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= in_func_i;
      idx_q  <= in_cell_index_i;
    end
  end

  always_comb begin
    cmd_o              = '0;
    cmd_o.wsel         = gdr_pkg::WS_IMPULSE;
    cmd_o.prep_en      = prep_en;
    cmd_o.has_left     = (pcol_q != '0);
    cmd_o.has_right    = (pcol_q != COL_LAST);
    cmd_o.has_up       = (prow_q != '0);
    cmd_o.has_down     = (prow_q != ROW_LAST);
    cmd_o.comp_en      = comp_en;
    cmd_o.capture      = (state_q == ST_CAPTURE);
    cmd_o.func_read    = (func_q == gdr_pkg::FUNC_READ);
    cmd_o.cell_in_grid = in_grid;
    cmd_o.out_load     = out_load;
    waddr_o            = idx_addr;
    raddr_o            = idx_addr;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = gdr_pkg::WS_ZERO;
        waddr_o      = k_q[AW-1:0];
      end
      ST_SWEEP: begin
        cmd_o.mem_we = comp_en;
        cmd_o.wsel   = gdr_pkg::WS_CELL;
        cmd_o.rd_en  = 1'b1;
        waddr_o      = k_wr[AW-1:0];
        raddr_o      = (k_q < K_N) ? k_q[AW-1:0] : '0;
      end
      ST_FETCH: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_CAPTURE: begin
        cmd_o.mem_we = (func_q == gdr_pkg::FUNC_STEP) && in_grid;
      end
      default: begin
        cmd_o.mem_we = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/gdr_dp.sv @@
`default_nettype none

module gdr_dp #(
  parameter int GRID_WIDTH  = gdr_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gdr_pkg::GRID_HEIGHT_DEF,
  localparam int N  = GRID_WIDTH * GRID_HEIGHT,
  localparam int AW = $clog2(N)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire gdr_pkg::cmd_t                     cmd_i,
  input  wire logic [AW-1:0]                     waddr_i,
  input  wire logic [AW-1:0]                     raddr_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [gdr_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [gdr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [gdr_pkg::CELL_W-1:0]             cell_value_o
);

  localparam int CW     = gdr_pkg::CELL_W;
  localparam int WW     = gdr_pkg::WEIGHT_W;
  localparam int FB     = gdr_pkg::FRAC_BITS;
  localparam int OWN_PW = WW + CW;
  localparam int OWN_W  = OWN_PW - FB;
  localparam int SUM_W  = CW + 2;
  localparam int REST_W = WW + SUM_W;
  localparam int LEFT_W = WW + CW;
  localparam int TOT_W  = REST_W + 1;
  localparam int NB_W   = TOT_W - FB;
  localparam int ACC_W  = NB_W + 1;

  logic [CW-1:0] grid_q [N];
  logic [CW-1:0] win_q  [GRID_WIDTH+1];
  logic [CW-1:0] nwin_q [GRID_WIDTH-1];

  logic [WW-1:0] sw_q;
  logic [WW-1:0] nw_q;
  logic [CW-1:0] imp_q;

  logic [OWN_W-1:0]  own_q;
  logic [REST_W-1:0] rest_q;
  logic              left_q;
  logic [CW-1:0]     res_q;
  logic [CW-1:0]     out_q;

  logic [CW-1:0]     nb_r, nb_u, nb_d, nb_l;
  logic [SUM_W-1:0]  rest_sum;
  logic [OWN_PW-1:0] own_prod;
  logic [REST_W-1:0] rest_prod;
  logic [LEFT_W-1:0] left_prod;
  logic [TOT_W-1:0]  tot;
  logic [ACC_W-1:0]  acc;
  logic [CW-1:0]     cell_new;
  logic [CW:0]       imp_sum;
  logic [CW-1:0]     imp_sat;
  logic [CW-1:0]     wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q  <= gdr_pkg::SELF_WEIGHT_RST;
      nw_q  <= gdr_pkg::NEIGHBOUR_WEIGHT_RST;
      imp_q <= gdr_pkg::IMPULSE_AMOUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gdr_pkg::REG_SELF_WEIGHT:      sw_q  <= cfg_data_i[WW-1:0];
        gdr_pkg::REG_NEIGHBOUR_WEIGHT: nw_q  <= cfg_data_i[WW-1:0];
        gdr_pkg::REG_IMPULSE_AMOUNT:   imp_q <= cfg_data_i[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  // prepare the next cell: own product and right, up, down neighbour product
  assign nb_r      = cmd_i.has_right ? win_q[GRID_WIDTH-1] : '0;
  assign nb_d      = cmd_i.has_down  ? win_q[0] : '0;
  assign nb_u      = cmd_i.has_up    ? nwin_q[GRID_WIDTH-2] : '0;
  assign rest_sum  = SUM_W'(nb_r) + SUM_W'(nb_u) + SUM_W'(nb_d);
  assign own_prod  = OWN_PW'(sw_q) * OWN_PW'(win_q[GRID_WIDTH]);
  assign rest_prod = REST_W'(nw_q) * REST_W'(rest_sum);

  // finish the cell with the freshly updated left neighbour
  assign nb_l      = left_q ? nwin_q[0] : '0;
  assign left_prod = LEFT_W'(nw_q) * LEFT_W'(nb_l);
  assign tot       = TOT_W'(left_prod) + TOT_W'(rest_q);
  assign acc       = ACC_W'(tot[TOT_W-1:FB]) + ACC_W'(own_q);
  assign cell_new  = (|acc[ACC_W-1:CW]) ? {CW{1'b1}} : acc[CW-1:0];

  assign imp_sum = {1'b0, win_q[0]} + {1'b0, imp_q};
  assign imp_sat = imp_sum[CW] ? {CW{1'b1}} : imp_sum[CW-1:0];

  always_comb begin
    case (cmd_i.wsel)
      gdr_pkg::WS_ZERO:    wdata = '0;
      gdr_pkg::WS_CELL:    wdata = cell_new;
      gdr_pkg::WS_IMPULSE: wdata = imp_sat;
      default:             wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      grid_q[waddr_i] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      win_q[0] <= grid_q[raddr_i];
      for (int i = 1; i <= GRID_WIDTH; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_en) begin
      nwin_q[0] <= cell_new;
      for (int i = 1; i < GRID_WIDTH - 1; i++) begin
        nwin_q[i] <= nwin_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep_en) begin
      own_q  <= own_prod[OWN_PW-1:FB];
      rest_q <= rest_prod;
      left_q <= cmd_i.has_left;
    end
    if (cmd_i.capture) begin
      res_q <= !cmd_i.cell_in_grid ? '0 : (cmd_i.func_read ? win_q[0] : imp_sat);
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign cell_value_o = out_q;

endmodule

`default_nettype wire

@@ src/grid_diffusion_relaxation_core.sv @@
// Grid relaxation core: holds a GRID_WIDTH x GRID_HEIGHT grid of unsigned Q4.12
// cells in one single-write, single-read memory. After reset the core clears
// the grid and takes no item meanwhile; configuration writes are taken at any
// time. For a step item the sweep streams the grid through the memory read
// port one cell per cycle, with a row-plus-one window of old values and a
// row-less-one window of new values in registers, then the impulse is read
// and written back. One item is in work at a time; its result waits in an
// output register while the next item is accepted.
`default_nettype none

module grid_diffusion_relaxation_core #(
  parameter int GRID_WIDTH  = gdr_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gdr_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gdr_in_if.sink      in_ch,
  gdr_out_if.source   out_ch,
  gdr_cfg_if.sink     cfg_ch
);

  localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);

  gdr_pkg::cmd_t  cmd;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;

  assign cfg_ch.ready = 1'b1;

  gdr_ctrl #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch.valid),
    .in_func_i       (in_ch.func),
    .in_cell_index_i (in_ch.cell_index),
    .in_ready_o      (in_ch.ready),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .cmd_o           (cmd),
    .waddr_o         (waddr),
    .raddr_o         (raddr)
  );

  gdr_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .waddr_i      (waddr),
    .raddr_i      (raddr),
    .cfg_we_i     (cfg_ch.valid),
    .cfg_index_i  (cfg_ch.reg_index),
    .cfg_data_i   (cfg_ch.wdata),
    .cell_value_o (out_ch.cell_value)
  );

endmodule

`default_nettype wire

@@ src/gdr_checker.sv @@
`default_nettype none

`include "grid_diffusion_relaxation_core_assert.svh"

module gdr_checker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gdr_in_if.sink      in_ch,
  gdr_out_if.source   out_ch
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] open_q;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // track items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `GDR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.cell_value), "result item changed while stalled")
  `GDR_ASSERT_NEXT(a_one_in_work, clk_i, rst_ni, in_acc, !in_ch.ready, "item accepted while another is in work")
  `GDR_ASSERT_NOW(a_no_invented, clk_i, rst_ni, out_ch.valid, open_q != 2'd0, "result item without an open item")
  `GDR_ASSERT_NOW(a_open_bound, clk_i, rst_ni, 1'b1, open_q != 2'd3, "more than two items open")

endmodule

bind grid_diffusion_relaxation_core gdr_checker u_gdr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

@@ test/gdr_result_checker.sv @@
`default_nettype none

module gdr_result_checker #(
  parameter int GRID_WIDTH  = gdr_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gdr_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gdr_in_if         in_mon,
  gdr_out_if        out_mon,
  gdr_cfg_if        cfg_mon,
  output int        errors_o,
  output int        pending_o
);

  import gdr_pkg::*;

  localparam int              CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam longint unsigned CELL_MAX   = 65535;

  logic [CELL_W-1:0]   cells [CELL_COUNT];
  logic [WEIGHT_W-1:0] self_w;
  logic [WEIGHT_W-1:0] nbr_w;
  logic [CELL_W-1:0]   impulse;
  logic [CELL_W-1:0]   expected_cells [$];
  int                  err_count    = 0;
  int                  result_count = 0;

  function automatic logic [CELL_W-1:0] sat_cell(longint unsigned v);
    return (v > CELL_MAX) ? {CELL_W{1'b1}} : v[CELL_W-1:0];
  endfunction

  // In-place raster sweep: left and upper neighbours are already updated.
  function automatic void relax_grid();
    int              pos;
    longint unsigned nsum;
    longint unsigned own;
    longint unsigned nb;
    for (int row = 0; row < GRID_HEIGHT; row++) begin
      for (int col = 0; col < GRID_WIDTH; col++) begin
        pos  = row * GRID_WIDTH + col;
        nsum = 0;
        if (col > 0)               nsum += cells[pos-1];
        if (col + 1 < GRID_WIDTH)  nsum += cells[pos+1];
        if (row > 0)               nsum += cells[pos-GRID_WIDTH];
        if (row + 1 < GRID_HEIGHT) nsum += cells[pos+GRID_WIDTH];
        own  = (longint'(self_w) * cells[pos]) >> FRAC_BITS;
        nb   = (longint'(nbr_w) * nsum) >> FRAC_BITS;
        cells[pos] = sat_cell(own + nb);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [CELL_W-1:0] want;
    logic [CELL_W-1:0] got;
    int                idx;
    if (!rst_ni) begin
      for (int i = 0; i < CELL_COUNT; i++) cells[i] = '0;
      self_w  = SELF_WEIGHT_RST;
      nbr_w   = NEIGHBOUR_WEIGHT_RST;
      impulse = IMPULSE_AMOUNT_RST;
      expected_cells.delete();
      pending_o <= 0;
      errors_o  <= err_count;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_index)
          REG_SELF_WEIGHT:      self_w  = cfg_mon.wdata[WEIGHT_W-1:0];
          REG_NEIGHBOUR_WEIGHT: nbr_w   = cfg_mon.wdata[WEIGHT_W-1:0];
          REG_IMPULSE_AMOUNT:   impulse = cfg_mon.wdata[CELL_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.cell_value;
        if (expected_cells.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("result %0d: cell_value %0d with no item pending", result_count, got);
          end
        end else begin
          want = expected_cells.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= 10) begin
              $display("result %0d: cell_value expected %0d got %0d",
                       result_count, want, got);
            end
          end
        end
        result_count++;
      end
      if (in_mon.valid && in_mon.ready) begin
        idx = int'(in_mon.cell_index);
        if (in_mon.func == FUNC_STEP) begin
          relax_grid();
          if (idx < CELL_COUNT) begin
            cells[idx] = sat_cell(longint'(cells[idx]) + impulse);
          end
        end
        expected_cells.push_back((idx < CELL_COUNT) ? cells[idx] : '0);
      end
      pending_o <= expected_cells.size();
      errors_o  <= err_count;
    end
  end

endmodule

`default_nettype wire

@@ test/tb_grid_diffusion_relaxation_core.sv @@
`default_nettype none

module tb_grid_diffusion_relaxation_core;

  import gdr_pkg::*;

  localparam int                     GRID_W       = GRID_WIDTH_DEF;
  localparam int                     GRID_H       = GRID_HEIGHT_DEF;
  localparam int                     RANDOM_ITEMS = 400;
  localparam int                     CYCLE_LIMIT  = 3_000_000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED   = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic no_idle;
  int   checker_errors;
  int   cells_pending;
  int   cycles;
  int   items_sent;
  int   phase_len;

  gdr_in_if  in_ch ();
  gdr_out_if out_ch ();
  gdr_cfg_if cfg_ch ();

  grid_diffusion_relaxation_core #(
    .GRID_WIDTH  (GRID_W),
    .GRID_HEIGHT (GRID_H)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  gdr_result_checker #(
    .GRID_WIDTH  (GRID_W),
    .GRID_HEIGHT (GRID_H)
  ) i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_mon   (cfg_ch),
    .errors_o  (checker_errors),
    .pending_o (cells_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_grid_diffusion_relaxation_core: done, errors");
    $finish;
  end

  // Result side: stall for a random time before each item unless no_idle is set.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  task automatic send_item(input logic func, input logic [INDEX_W-1:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.cell_index <= idx;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off until every issued item has returned its cell.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (cells_pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WEIGHT_W'(4096);
      2:       return {WEIGHT_W{1'b1}};
      default: return WEIGHT_W'($urandom_range(lo, hi));
    endcase
  endfunction

  initial begin
    rst_ni           <= 1'b0;
    no_idle          <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_STEP;
    in_ch.cell_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_SELF_WEIGHT;
    cfg_ch.wdata     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners, edges and inner cells at the reset weights.
    send_item(FUNC_READ, 10'd0);
    send_item(FUNC_READ, 10'd1023);
    send_item(FUNC_STEP, 10'd0);
    send_item(FUNC_STEP, 10'd1023);
    send_item(FUNC_STEP, 10'd31);
    send_item(FUNC_STEP, 10'd992);
    send_item(FUNC_READ, 10'd1);
    send_item(FUNC_READ, 10'd32);
    send_item(FUNC_READ, 10'd1022);
    send_item(FUNC_STEP, 10'd500);
    send_item(FUNC_READ, 10'd501);
    drain();

    // Impulse saturation: unit self weight, no spread, full impulse.
    write_reg(REG_SELF_WEIGHT, 16'd4096);
    write_reg(REG_NEIGHBOUR_WEIGHT, 16'd0);
    write_reg(REG_IMPULSE_AMOUNT, 16'hFFFF);
    send_item(FUNC_STEP, 10'd7);
    send_item(FUNC_STEP, 10'd7);
    send_item(FUNC_READ, 10'd7);
    drain();

    // Weights above one, upper data bits set: sum saturation.
    write_reg(REG_SELF_WEIGHT, 16'hFFFF);
    write_reg(REG_NEIGHBOUR_WEIGHT, 16'hFFFF);
    write_reg(REG_IMPULSE_AMOUNT, 16'd0);
    send_item(FUNC_STEP, 10'd300);
    send_item(FUNC_STEP, 10'd300);
    send_item(FUNC_READ, 10'd0);
    drain();

    // Zero weights wipe the grid; the unused index must change nothing.
    write_reg(REG_SELF_WEIGHT, 16'd0);
    write_reg(REG_NEIGHBOUR_WEIGHT, 16'd0);
    write_reg(REG_UNUSED, 16'hA5A5);
    send_item(FUNC_STEP, 10'd1023);
    send_item(FUNC_READ, 10'd300);
    drain();

    write_reg(REG_SELF_WEIGHT, 16'(SELF_WEIGHT_RST));
    write_reg(REG_NEIGHBOUR_WEIGHT, 16'(NEIGHBOUR_WEIGHT_RST));
    write_reg(REG_IMPULSE_AMOUNT, IMPULSE_AMOUNT_RST);
    write_reg(REG_UNUSED, 16'h5A5A);
    send_item(FUNC_STEP, 10'd0);
    send_item(FUNC_READ, 10'd0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      write_reg(REG_SELF_WEIGHT, {3'($urandom_range(0, 7)), pick_weight(2400, 4096)});
      write_reg(REG_NEIGHBOUR_WEIGHT, {3'($urandom_range(0, 7)), pick_weight(0, 400)});
      case ($urandom_range(0, 3))
        0:       write_reg(REG_IMPULSE_AMOUNT, 16'hFFFF);
        1:       write_reg(REG_IMPULSE_AMOUNT, 16'h0000);
        default: write_reg(REG_IMPULSE_AMOUNT, 16'($urandom));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, 16'($urandom));
      end
      no_idle   <= ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(25, 50);
      repeat (phase_len) begin
        send_item(($urandom_range(0, 9) < 4) ? FUNC_STEP : FUNC_READ,
                  INDEX_W'($urandom_range(0, 1023)));
        items_sent++;
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (checker_errors == 0 && cells_pending == 0) begin
      $display("tb_grid_diffusion_relaxation_core: done, clean");
    end else begin
      $display("tb_grid_diffusion_relaxation_core: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
